@@ rtl/core/tcw_pkg.sv @@
// tcw_pkg: shared types and constants of the text console writer.
// Holds the port item structs, the decoded command and the queue depth.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

	// Opcodes of an input item
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_MOVE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] CLEAR_COLOR_RESET = 8'd15;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [7:0] char_color;
		logic [4:0] target_row;
		logic [6:0] target_col;
	} in_item_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] cell_char;
		logic [7:0] cell_color;
		logic       scrolled;
	} out_item_t;

	// Decoded kind of work for the back end
	typedef enum logic [2:0] {
		K_PUT     = 3'd0,
		K_NEWLINE = 3'd1,
		K_MOVE    = 3'd2,
		K_CLEAR   = 3'd3,
		K_READ    = 3'd4
	} kind_t;

	// Row and column are already saturated to the screen bounds
	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_code;
		logic [7:0] char_color;
		logic [4:0] row;
		logic [6:0] col;
	} cmd_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

@@ rtl/core/tcw_front.sv @@
// tcw_front: accepts input items, decodes the opcode and saturates targets.
// Depends on tcw_pkg; feeds tcw_queue.
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic      in_valid,
	input  in_item_t  in_item,
	input  logic      q_full,
	output logic      push,
	output cmd_t      push_cmd
);

	localparam logic [6:0] ROW_MAX = 7'(ROWS - 1);
	localparam logic [7:0] COL_MAX = 8'(COLS - 1);

	logic [4:0] row_sat;
	logic [6:0] col_sat;

	// Clamp targets that lie beyond the last row or column
	assign row_sat = ({2'b00, in_item.target_row} > ROW_MAX) ? ROW_MAX[4:0]
	                                                          : in_item.target_row;
	assign col_sat = ({1'b0, in_item.target_col} > COL_MAX) ? COL_MAX[6:0]
	                                                         : in_item.target_col;

	assign push = in_valid && !q_full;

	// Classify the item
	always_comb begin
		push_cmd.char_code  = in_item.char_code;
		push_cmd.char_color = in_item.char_color;
		push_cmd.row        = row_sat;
		push_cmd.col        = col_sat;
		case (in_item.opcode)
			OP_PUT: begin
				push_cmd.kind = (in_item.char_code == NEWLINE_CODE) ? K_NEWLINE : K_PUT;
			end
			OP_MOVE:  push_cmd.kind = K_MOVE;
			OP_CLEAR: push_cmd.kind = K_CLEAR;
			OP_READ:  push_cmd.kind = K_READ;
			default:  push_cmd.kind = K_READ;
		endcase
	end

endmodule

@@ rtl/core/tcw_queue.sv @@
// tcw_queue: short command queue between the front and the back end.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output logic    full,
	output q_head_t head
);

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tcw_back.sv @@
// tcw_back: executes console commands against the cell store and cursor.
// Holds the cell memory, the sweep sequencer and the result register.
// Depends on tcw_pkg; takes commands from tcw_queue.
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] clear_color,
	input  q_head_t   head,
	output logic      pop,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_stall
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);

	typedef enum logic [3:0] {
		ST_FILL   = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             init_q;
	logic [15:0]      fill_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic             scrolled_q;
	logic             is_read_q;
	logic             wr_pend_s1;
	logic [AW-1:0]    wr_addr_s1;
	logic             wr_zero_s1;
	logic [15:0]      rd_data_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [15:0]   mem [CELLS];
	logic          we;
	logic          re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [15:0]   wdata;

	logic [AW-1:0] cur_addr;
	logic [AW-1:0] tgt_addr;
	logic          advance;
	logic          need_scroll;
	logic [RW-1:0] nxt_row;
	logic [CW-1:0] nxt_col;
	logic          load_ok;
	out_item_t     result;

	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign load_ok   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign cur_addr = AW'(row_q * COLS + col_q);
	assign tgt_addr = AW'(head.cmd.row * COLS + head.cmd.col);

	// Cursor advance for a character or a newline
	always_comb begin
		advance     = (head.cmd.kind == K_NEWLINE) || (col_q == CW'(COLS - 1));
		need_scroll = advance && (row_q == RW'(ROWS - 1));
		nxt_col     = advance ? '0 : col_q + 1'b1;
		if (advance && !need_scroll) begin
			nxt_row = row_q + 1'b1;
		end else begin
			nxt_row = row_q;
		end
	end

	// Memory port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		case (state_q)
			ST_FILL: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = fill_q;
			end
			ST_IDLE: begin
				if (head.valid && head.cmd.kind == K_PUT) begin
					we    = 1'b1;
					waddr = cur_addr;
					wdata = {head.cmd.char_color, head.cmd.char_code};
				end
				if (head.valid && head.cmd.kind == K_READ) begin
					re    = 1'b1;
					raddr = tgt_addr;
				end
			end
			ST_SCROLL: begin
				// write follows, in the next cycle, the read of the row below
				if (wr_pend_s1) begin
					we    = 1'b1;
					waddr = wr_addr_s1;
					wdata = wr_zero_s1 ? 16'h0000 : rd_data_q;
				end
				if (cnt_q < CNT_W'(CELLS - COLS)) begin
					re    = 1'b1;
					raddr = AW'(cnt_q + COLS);
				end
			end
			default: begin
			end
		endcase
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// Result assembled from the cursor and the read data
	always_comb begin
		result.cursor_row = 5'(row_q);
		result.cursor_col = 7'(col_q);
		result.cell_char  = is_read_q ? rd_data_q[7:0]  : 8'h00;
		result.cell_color = is_read_q ? rd_data_q[15:8] : 8'h00;
		result.scrolled   = scrolled_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			init_q      <= 1'b1;
			fill_q      <= 16'h0000;
			row_q       <= '0;
			col_q       <= '0;
			scrolled_q  <= 1'b0;
			is_read_q   <= 1'b0;
			wr_pend_s1  <= 1'b0;
			wr_addr_s1  <= '0;
			wr_zero_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load on a finished item, drop once taken
			if (state_q == ST_RESP && load_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						cnt_q   <= '0;
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						is_read_q  <= (head.cmd.kind == K_READ);
						wr_pend_s1 <= 1'b0;
						cnt_q      <= '0;
						case (head.cmd.kind)
							K_PUT, K_NEWLINE: begin
								row_q      <= nxt_row;
								col_q      <= nxt_col;
								scrolled_q <= need_scroll;
								state_q    <= need_scroll ? ST_SCROLL : ST_RESP;
							end
							K_MOVE: begin
								row_q      <= RW'(head.cmd.row);
								col_q      <= CW'(head.cmd.col);
								scrolled_q <= 1'b0;
								state_q    <= ST_RESP;
							end
							K_CLEAR: begin
								fill_q     <= {clear_color, SPACE_CODE};
								row_q      <= '0;
								col_q      <= '0;
								scrolled_q <= 1'b0;
								state_q    <= ST_FILL;
							end
							default: begin
								scrolled_q <= 1'b0;
								state_q    <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCROLL: begin
					wr_addr_s1 <= cnt_q[AW-1:0];
					wr_zero_s1 <= (cnt_q >= CNT_W'(CELLS - COLS));
					if (cnt_q == CNT_W'(CELLS)) begin
						wr_pend_s1 <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_RESP;
					end else begin
						wr_pend_s1 <= 1'b1;
						cnt_q      <= cnt_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && load_ok) begin
			out_q <= result;
		end
	end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: character cell store with cursor, scroll, clear and read.
// Put char, newline, move and read go from queue head to the result register
// through execute (ST_IDLE), then result (ST_RESP); the next pops in ST_IDLE.
// A clear adds a fill and a scroll a shift over the cells, one cell per cycle.
// After reset the cell memory is zeroed in a pass over all ROWS*COLS cells during
// which no item leaves the queue; up to two items are taken meanwhile.
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item
);

	logic [7:0] clear_color_q;
	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	logic       q_full;
	q_head_t    head;

	// Clear color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_color_q <= CLEAR_COLOR_RESET;
		end else if (cfg_wr_en) begin
			clear_color_q <= cfg_wr_data;
		end
	end

	assign in_stall = q_full;

	tcw_front #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_front (
		.in_valid(in_valid),
		.in_item (in_item),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.head    (head)
	);

	tcw_back #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_color(clear_color_q),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_item   (out_item),
		.out_stall  (out_stall)
	);

`ifndef SYNTHESIS
	// Cursor column stays on screen
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_item.cursor_col} < 8'(COLS)))
		else $error("cursor column beyond last column");

	// A scroll leaves the cursor at the start of the last row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.scrolled) |-> (out_item.cursor_row == 5'(ROWS - 1)))
		else $error("scroll result not on last row");

	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.scrolled) |-> (out_item.cursor_col == 7'd0))
		else $error("scroll result not at column zero");

	// A scroll never reports cell data
	a_scroll_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.scrolled) |->
			(out_item.cell_char == 8'h00 && out_item.cell_color == 8'h00))
		else $error("scroll result carries cell data");
`endif

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for text_console_writer (put, newline, move, clear, read, scroll).
// Carries a cell-accurate console predictor in a scoreboard class; depends on tcw_pkg
// and the text_console_writer RTL only.
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	localparam int ROWS = 25;
	localparam int COLS = 80;
	localparam int CELLS = ROWS * COLS;
	localparam int PHASE_ITEMS = 310;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT = 12_000_000;

	// Shadow console: cell store, cursor and clear color, plus the reports still owed
	class console_scoreboard;
		logic [15:0] cells [CELLS];
		int unsigned cursor;
		logic [7:0] clear_color;
		out_item_t owed_reports[$];
		int errors;

		function new();
			foreach (cells[i]) cells[i] = '0;
			cursor = 0;
			clear_color = CLEAR_COLOR_RESET;
			errors = 0;
		endfunction

		function int unsigned clamp_row(logic [4:0] r);
			return (r > ROWS - 1) ? ROWS - 1 : r;
		endfunction

		function int unsigned clamp_col(logic [6:0] c);
			return (c > COLS - 1) ? COLS - 1 : c;
		endfunction

		// Every row moves up one, bottom row becomes zero
		function void scroll_up();
			for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = '0;
		endfunction

		// Apply one command to the shadow console and queue the report it owes
		function void note_command(in_item_t cmd);
			out_item_t rep;
			int unsigned nxt;
			int unsigned idx;
			rep = '0;
			if (cursor >= CELLS) cursor = 0;
			case (cmd.opcode)
				OP_PUT: begin
					if (cmd.char_code == NEWLINE_CODE) begin
						nxt = (cursor / COLS + 1) * COLS;
					end else begin
						cells[cursor] = {cmd.char_color, cmd.char_code};
						nxt = cursor + 1;
					end
					if (nxt >= CELLS) begin
						scroll_up();
						nxt -= COLS;
						rep.scrolled = 1'b1;
					end
					cursor = nxt;
				end
				OP_MOVE: begin
					cursor = clamp_row(cmd.target_row) * COLS + clamp_col(cmd.target_col);
				end
				OP_CLEAR: begin
					foreach (cells[i]) cells[i] = {clear_color, SPACE_CODE};
					cursor = 0;
				end
				default: begin
					idx = clamp_row(cmd.target_row) * COLS + clamp_col(cmd.target_col);
					rep.cell_char = cells[idx][7:0];
					rep.cell_color = cells[idx][15:8];
				end
			endcase
			rep.cursor_row = 5'(cursor / COLS);
			rep.cursor_col = 7'(cursor % COLS);
			owed_reports.push_back(rep);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_report(out_item_t got);
			out_item_t want;
			if (owed_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none expected, actual %p", $time, got);
				return;
			end
			want = owed_reports.pop_front();
			compare_field("cursor_row", want.cursor_row, got.cursor_row);
			compare_field("cursor_col", want.cursor_col, got.cursor_col);
			compare_field("cell_char", want.cell_char, got.cell_char);
			compare_field("cell_color", want.cell_color, got.cell_color);
			compare_field("scrolled", want.scrolled, got.scrolled);
		endfunction

		function int pending();
			return owed_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;

	console_scoreboard sb;
	int unsigned cycles;
	bit tx_calm;
	bit rx_calm;
	bit hold_req;
	int burst_left;

	text_console_writer #(.ROWS(ROWS), .COLS(COLS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_report(out_item);
			if (in_valid && !in_stall) sb.note_command(in_item);
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 34);
			end
		end
	end

	// Watchdog
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic in_item_t make_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] color,
			logic [4:0] row, logic [6:0] col);
		in_item_t it;
		it.opcode = op;
		it.char_code = ch;
		it.char_color = color;
		it.target_row = row;
		it.target_col = col;
		return it;
	endfunction

	// Random command: mostly text, moves biased toward the bottom row to provoke scrolls
	function automatic in_item_t random_cmd();
		in_item_t it;
		int unsigned pick;
		it = make_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			it.opcode = OP_PUT;
			if ($urandom_range(0, 9) == 0) it.char_code = NEWLINE_CODE;
		end else if (pick < 75) begin
			it.opcode = OP_MOVE;
			if ($urandom_range(0, 2) == 0) it.target_row = 5'($urandom_range(22, 31));
			if ($urandom_range(0, 3) == 0) it.target_col = 7'($urandom_range(70, 127));
		end else if (pick < 97) begin
			it.opcode = OP_READ;
		end else begin
			it.opcode = OP_CLEAR;
		end
		return it;
	endfunction

	// Offer one item and hold it until taken
	task automatic send_command(in_item_t it);
		while (!tx_calm && burst_left == 0 && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_for_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Register write, for use only while the console is idle; the task does not enforce this
	task automatic write_clear_color(logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.clear_color = value;
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus
	initial begin
		in_item_t directed[$];
		logic [7:0] phase_color[4];
		sb = new();
		cycles = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_clear_color(8'h00);

		// Directed: field extremes, saturation, newline, wrap and scroll corners
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd31, 7'd127));
		directed.push_back(make_cmd(OP_PUT, 8'h00, 8'hFF, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_PUT, 8'hFF, 8'h00, 5'd31, 7'd127));
		directed.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 8'hAA, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd1));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd31, 7'd127));
		directed.push_back(make_cmd(OP_PUT, 8'h41, 8'h5A, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd23, 7'd79));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd24, 7'd0));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd24, 7'd5));
		directed.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd22, 7'd79));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd0, 7'd127));
		directed.push_back(make_cmd(OP_PUT, 8'h7E, 8'h81, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd24, 7'd100));
		directed.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd25, 7'd0));
		directed.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd0, 7'd79));
		directed.push_back(make_cmd(OP_MOVE, 8'h00, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0));
		directed.push_back(make_cmd(OP_READ, 8'h00, 8'h00, 5'd12, 7'd40));
		foreach (directed[i]) send_command(directed[i]);
		wait_for_reports();

		// Random phases, one clear color each
		phase_color[0] = 8'hFF;
		phase_color[1] = 8'($urandom_range(1, 254));
		phase_color[2] = CLEAR_COLOR_RESET;
		phase_color[3] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 4; p++) begin
			write_clear_color(phase_color[p]);
			tx_calm = (p == 2);
			rx_calm = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (p == 1 && n == 50) begin
					hold_req = 1'b1;
					burst_left = 30;
				end
				// sender pause until the console has caught up
				if (p == 0 && n == 200) wait_for_reports();
				send_command(random_cmd());
			end
			wait_for_reports();
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
